// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for concurrent assertions used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/wads_pkg.sv -----
// ---------------------------------------------------------------------------
// wads_pkg
// Types, register codes and helpers of the waypoint arrive/dwell sequencer.
// ---------------------------------------------------------------------------
package wads_pkg;

  localparam logic [7:0]  STABLE_MAX = 8'hFF;
  localparam logic [19:0] DWELL_MAX  = 20'hFFFFF;

  typedef enum logic [2:0] {
    REG_XY_TOL     = 3'd0,
    REG_Z_TOL      = 3'd1,
    REG_XY_SPD     = 3'd2,
    REG_Z_SPD      = 3'd3,
    REG_STABLE_REQ = 3'd4,
    REG_DWELL_DUR  = 3'd5,
    REG_WP_COUNT   = 3'd6,
    REG_HOLD_ALT   = 3'd7
  } wads_reg_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [9:0]  tick_ms;
    logic               finish_early;
  } wads_item_t;

  typedef struct packed {
    logic               status;
    logic        [7:0]  waypoint_index;
    logic               in_dwell;
    logic               entered_cell;
    logic               left_cell;
    logic        [19:0] dwell_elapsed_ms;
    logic        [7:0]  stable_run;
    logic signed [15:0] setpoint_x;
    logic signed [15:0] setpoint_y;
  } wads_result_t;

  typedef struct packed {
    logic        [15:0] xy_tolerance;
    logic        [15:0] z_tolerance;
    logic        [15:0] xy_speed_limit;
    logic        [15:0] z_speed_limit;
    logic        [7:0]  stable_ticks_needed;
    logic        [19:0] dwell_duration_ms;
    logic        [7:0]  waypoint_count;
    logic signed [15:0] hold_altitude;
  } wads_cfg_t;

  // Classified tick handed from front to back.
  typedef struct packed {
    logic               good;
    logic        [9:0]  tick_ms;
    logic               finish_early;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } wads_cls_t;

  // |a - b| of two signed 16-bit values; always fits in 16 bits unsigned.
  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] d;
    logic [16:0] n;
    d = {a[15], a} - {b[15], b};
    n = 17'd0 - d;
    return d[16] ? n[15:0] : d[15:0];
  endfunction

endpackage

// ----- rtl/wads_fifo.sv -----
// ---------------------------------------------------------------------------
// wads_fifo
// Small register FIFO with show-ahead read.
// ---------------------------------------------------------------------------
module wads_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/wads_front.sv -----
// ---------------------------------------------------------------------------
// wads_front
// Accepts ticks and classifies them: squares in one stage, sums and
// tolerance compares in the next, then pushes into the mid queue.
// ---------------------------------------------------------------------------
module wads_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  wads_pkg::wads_item_t  item,
  input  wads_pkg::wads_cfg_t   cfg,
  output logic                  mid_push,
  output wads_pkg::wads_cls_t   mid_data,
  input  logic                  mid_full
);
  import wads_pkg::*;

  logic        s1_vld;
  logic [31:0] sq_dx;
  logic [31:0] sq_dy;
  logic [31:0] sq_vx;
  logic [31:0] sq_vy;
  logic [31:0] tol_sq;
  logic [31:0] spd_sq;
  logic        z_ok;
  logic        vz_ok;
  logic [9:0]  tick_ms;
  logic        finish_early;
  logic [15:0] target_x;
  logic [15:0] target_y;

  logic        load;
  logic [15:0] dx_mag;
  logic [15:0] dy_mag;
  logic [15:0] dz_mag;
  logic [15:0] vx_mag;
  logic [15:0] vy_mag;
  logic [15:0] vz_mag;
  logic [32:0] xy_sum;
  logic [32:0] v_sum;
  logic        xy_ok;
  logic        vxy_ok;

  // Stage 1 stalls only when it is holding an item the queue cannot take.
  assign full     = s1_vld && mid_full;
  assign load     = push && !full;
  assign mid_push = s1_vld && !mid_full;

  assign dx_mag = abs_diff(item.pos_x, item.target_x);
  assign dy_mag = abs_diff(item.pos_y, item.target_y);
  assign dz_mag = abs_diff(item.pos_z, cfg.hold_altitude);
  assign vx_mag = abs_diff(item.vel_x, 16'd0);
  assign vy_mag = abs_diff(item.vel_y, 16'd0);
  assign vz_mag = abs_diff(item.vel_z, 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (load) begin
      s1_vld <= 1'b1;
    end else if (mid_push) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sq_dx        <= 32'(dx_mag) * 32'(dx_mag);
      sq_dy        <= 32'(dy_mag) * 32'(dy_mag);
      sq_vx        <= 32'(vx_mag) * 32'(vx_mag);
      sq_vy        <= 32'(vy_mag) * 32'(vy_mag);
      tol_sq       <= 32'(cfg.xy_tolerance) * 32'(cfg.xy_tolerance);
      spd_sq       <= 32'(cfg.xy_speed_limit) * 32'(cfg.xy_speed_limit);
      z_ok         <= (dz_mag <= cfg.z_tolerance);
      vz_ok        <= (vz_mag < cfg.z_speed_limit);
      tick_ms      <= item.tick_ms;
      finish_early <= item.finish_early;
      target_x     <= item.target_x;
      target_y     <= item.target_y;
    end
  end

  assign xy_sum = {1'b0, sq_dx} + {1'b0, sq_dy};
  assign v_sum  = {1'b0, sq_vx} + {1'b0, sq_vy};
  assign xy_ok  = (xy_sum <= {1'b0, tol_sq});
  assign vxy_ok = (v_sum < {1'b0, spd_sq});

  always_comb begin
    mid_data.good         = xy_ok && z_ok && vxy_ok && vz_ok;
    mid_data.tick_ms      = tick_ms;
    mid_data.finish_early = finish_early;
    mid_data.target_x     = target_x;
    mid_data.target_y     = target_y;
  end

endmodule

// ----- rtl/wads_back.sv -----
// ---------------------------------------------------------------------------
// wads_back
// Goto/dwell sequencer state; takes classified ticks and emits one result
// per tick into the output queue.
// ---------------------------------------------------------------------------
module wads_back #(
  parameter int unsigned MAX_WAYPOINTS = 255
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wads_pkg::wads_cfg_t    cfg,
  input  logic                   mid_empty,
  input  wads_pkg::wads_cls_t    mid_data,
  output logic                   mid_pop,
  input  logic                   out_full,
  output logic                   out_push,
  output wads_pkg::wads_result_t out_data
);
  import wads_pkg::*;

  localparam logic [7:0] WP_CAP = (MAX_WAYPOINTS > 255) ? 8'd255 : 8'(MAX_WAYPOINTS);

  logic        dwelling;
  logic [7:0]  stable_counter;
  logic [19:0] dwell_accum;
  logic [7:0]  current_waypoint;

  logic        dwelling_next;
  logic [7:0]  stable_counter_next;
  logic [19:0] dwell_accum_next;
  logic [7:0]  current_waypoint_next;

  logic        fire;
  logic [7:0]  eff_count;
  logic        finished;
  logic [20:0] acc_sum;
  logic [19:0] acc_sat;
  logic [7:0]  cnt_upd;

  assign fire     = !mid_empty && !out_full;
  assign mid_pop  = fire;
  assign out_push = fire;

  assign eff_count = (cfg.waypoint_count > WP_CAP) ? WP_CAP : cfg.waypoint_count;
  assign finished  = (eff_count == 8'd0) || mid_data.finish_early ||
                     (current_waypoint >= eff_count);
  assign acc_sum   = {1'b0, dwell_accum} + 21'(mid_data.tick_ms);
  assign acc_sat   = acc_sum[20] ? DWELL_MAX : acc_sum[19:0];

  always_comb begin
    dwelling_next         = dwelling;
    stable_counter_next   = stable_counter;
    dwell_accum_next      = dwell_accum;
    current_waypoint_next = current_waypoint;
    cnt_upd               = 8'd0;
    out_data              = '0;

    if (finished) begin
      // Report only; the stored state is left alone.
      out_data.status = 1'b1;
    end else if (dwelling) begin
      dwell_accum_next = acc_sat;
      if (acc_sat >= cfg.dwell_duration_ms) begin
        dwelling_next         = 1'b0;
        dwell_accum_next      = 20'd0;
        stable_counter_next   = 8'd0;
        current_waypoint_next = current_waypoint + 8'd1;
        out_data.left_cell    = 1'b1;
      end
    end else begin
      if (mid_data.good) begin
        cnt_upd = (stable_counter == STABLE_MAX) ? STABLE_MAX : stable_counter + 8'd1;
      end
      stable_counter_next = cnt_upd;
      // A zero requirement enters dwell even on a missed tick.
      if (cnt_upd >= cfg.stable_ticks_needed) begin
        stable_counter_next   = 8'd0;
        dwelling_next         = 1'b1;
        dwell_accum_next      = 20'd0;
        out_data.entered_cell = 1'b1;
      end
    end

    out_data.waypoint_index   = current_waypoint_next;
    out_data.in_dwell         = dwelling_next;
    out_data.dwell_elapsed_ms = dwell_accum_next;
    out_data.stable_run       = stable_counter_next;
    if (!finished) begin
      out_data.setpoint_x = mid_data.target_x;
      out_data.setpoint_y = mid_data.target_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwelling         <= 1'b0;
      stable_counter   <= 8'd0;
      dwell_accum      <= 20'd0;
      current_waypoint <= 8'd0;
    end else if (fire) begin
      dwelling         <= dwelling_next;
      stable_counter   <= stable_counter_next;
      dwell_accum      <= dwell_accum_next;
      current_waypoint <= current_waypoint_next;
    end
  end

endmodule

// ----- rtl/waypoint_arrive_dwell_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// waypoint_arrive_dwell_sequencer_core
// Arrive-and-dwell waypoint sequencer with APB register port.
// ---------------------------------------------------------------------------
// Usage:
//   Tick items enter on push/full and are taken when push is high and full
//   is low. One result per tick leaves on empty/pop, oldest first; the head
//   result sits on the result port while empty is low.
//   Path: a taken tick passes the square stage, the compare stage into the
//   mid queue and the sequencer step into the output queue, each registered.
//   Throughput: one tick per cycle while the receiver pops, set by the
//   sequencer step on the mid queue head.
//   Receiver stall: results collect in the output queue, then the mid
//   queue fills, then full rises; nothing is dropped and ticks resume one
//   per cycle once pop returns.
//   Reset: both queues empty, sequencer state cleared to waypoint 0 in
//   goto, registers back to their defaults. No clearing pass.
//   Registers sit at byte address 4*i; write them only while no ticks are
//   in flight.
// ---------------------------------------------------------------------------
module waypoint_arrive_dwell_sequencer_core #(
  parameter int unsigned MAX_WAYPOINTS = 255,
  parameter int unsigned MID_DEPTH     = 4,
  parameter int unsigned OUT_DEPTH     = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  wads_pkg::wads_item_t   item,
  output logic                   empty,
  input  logic                   pop,
  output wads_pkg::wads_result_t result,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import wads_pkg::*;

  wads_cfg_t    cfg;
  wads_reg_t    reg_sel;
  logic         cfg_wr;
  logic         mid_push;
  logic         mid_full;
  logic         mid_pop;
  logic         mid_empty;
  wads_cls_t    mid_wdata;
  wads_cls_t    mid_rdata;
  logic         out_push;
  logic         out_full;
  wads_result_t out_wdata;

  assign pready  = 1'b1;
  assign reg_sel = wads_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xy_tolerance        <= 16'd300;
      cfg.z_tolerance         <= 16'd200;
      cfg.xy_speed_limit      <= 16'd150;
      cfg.z_speed_limit       <= 16'd100;
      cfg.stable_ticks_needed <= 8'd10;
      cfg.dwell_duration_ms   <= 20'd2000;
      cfg.waypoint_count      <= 8'd0;
      cfg.hold_altitude       <= 16'sd0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_XY_TOL:     cfg.xy_tolerance        <= pwdata[15:0];
        REG_Z_TOL:      cfg.z_tolerance         <= pwdata[15:0];
        REG_XY_SPD:     cfg.xy_speed_limit      <= pwdata[15:0];
        REG_Z_SPD:      cfg.z_speed_limit       <= pwdata[15:0];
        REG_STABLE_REQ: cfg.stable_ticks_needed <= pwdata[7:0];
        REG_DWELL_DUR:  cfg.dwell_duration_ms   <= pwdata[19:0];
        REG_WP_COUNT:   cfg.waypoint_count      <= pwdata[7:0];
        REG_HOLD_ALT:   cfg.hold_altitude       <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_XY_TOL:     prdata = {16'd0, cfg.xy_tolerance};
      REG_Z_TOL:      prdata = {16'd0, cfg.z_tolerance};
      REG_XY_SPD:     prdata = {16'd0, cfg.xy_speed_limit};
      REG_Z_SPD:      prdata = {16'd0, cfg.z_speed_limit};
      REG_STABLE_REQ: prdata = {24'd0, cfg.stable_ticks_needed};
      REG_DWELL_DUR:  prdata = {12'd0, cfg.dwell_duration_ms};
      REG_WP_COUNT:   prdata = {24'd0, cfg.waypoint_count};
      REG_HOLD_ALT:   prdata = {16'd0, cfg.hold_altitude};
    endcase
  end

  wads_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cfg      (cfg),
    .mid_push (mid_push),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  wads_fifo #(
    .W     ($bits(wads_cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  wads_back #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  wads_fifo #(
    .W     ($bits(wads_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ----- rtl/wads_checker.sv -----
// ---------------------------------------------------------------------------
// wads_checker
// Port-level checks of the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wads_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input wads_pkg::wads_result_t result
);
  import wads_pkg::*;

  // Both queues come out of reset empty.
  `ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, empty && !full)

  // A waiting result holds until popped.
  `ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result))

  // Finished reports carry no events and no setpoint.
  `ASSERT_IMP(a_done_quiet, clk, rst, !empty && result.status,
    !result.entered_cell && !result.left_cell && result.setpoint_x == 16'sd0 &&
    result.setpoint_y == 16'sd0)

  // Arrival starts a fresh dwell with a cleared count.
  `ASSERT_IMP(a_enter, clk, rst, !empty && result.entered_cell,
    result.in_dwell && !result.left_cell && result.stable_run == 8'd0 &&
    result.dwell_elapsed_ms == 20'd0)

  // Leaving a cell clears the dwell state.
  `ASSERT_IMP(a_leave, clk, rst, !empty && result.left_cell,
    !result.in_dwell && result.stable_run == 8'd0 && result.dwell_elapsed_ms == 20'd0)

endmodule

bind waypoint_arrive_dwell_sequencer_core wads_checker u_wads_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the waypoint arrive/dwell sequencer: a short
// scripted run over the special cases, then randomized traversals under
// several register settings, each result checked against an in-bench
// model of the sequencer or against a fixed expected result.
// ---------------------------------------------------------------------------
module tb;
  import wads_pkg::*;

  localparam int MAX_WP    = 255;
  localparam int HOLD_AT   = 60;   // results taken before the long receiver stall
  localparam int LONG_HOLD = 80;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    wads_reg_t    reg_sel;
    logic [31:0]  value;
    wads_item_t   tick;
    bit           fixed;
    wads_result_t want;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         push;
  logic         full;
  wads_item_t   tick_bus;
  logic         empty;
  logic         pop;
  wads_result_t res_bus;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // model of the sequencer: registers and state
  wads_cfg_t    regs;
  bit           at_dwell;
  bit [7:0]     run_len;
  bit [19:0]    dwell_ms;
  bit [7:0]     wp_idx;

  wads_result_t pending_results[$];
  stim_row_t    script[$];
  int           n_bad;
  int           n_taken;
  bit           calm;

  waypoint_arrive_dwell_sequencer_core DUT (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (tick_bus),
    .empty   (empty),
    .pop     (pop),
    .result  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int cap_count(input int n);
    return (n > MAX_WP) ? MAX_WP : n;
  endfunction

  // extremes now and then, otherwise a value from the usual range
  function automatic int pick(input int lo, input int hi, input int typ_lo, input int typ_hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
    endcase
  endfunction

  function automatic void apply_reg(input wads_reg_t r, input logic [31:0] v);
    case (r)
      REG_XY_TOL:     regs.xy_tolerance        = v[15:0];
      REG_Z_TOL:      regs.z_tolerance         = v[15:0];
      REG_XY_SPD:     regs.xy_speed_limit      = v[15:0];
      REG_Z_SPD:      regs.z_speed_limit       = v[15:0];
      REG_STABLE_REQ: regs.stable_ticks_needed = v[7:0];
      REG_DWELL_DUR:  regs.dwell_duration_ms   = v[19:0];
      REG_WP_COUNT:   regs.waypoint_count      = v[7:0];
      REG_HOLD_ALT:   regs.hold_altitude       = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic wads_result_t advance_sequencer(input wads_item_t t);
    wads_result_t r;
    int unsigned  n_wp;
    longint       dx, dy, dz, lim, acc;
    bit           all_ok;
    r = '0;
    n_wp = (regs.waypoint_count > MAX_WP) ? MAX_WP : regs.waypoint_count;
    if (n_wp == 0 || t.finish_early || wp_idx >= n_wp) begin
      // finished: report stored state, change nothing
      r.status           = 1'b1;
      r.waypoint_index   = wp_idx;
      r.in_dwell         = at_dwell;
      r.dwell_elapsed_ms = dwell_ms;
      r.stable_run       = run_len;
      return r;
    end
    if (at_dwell) begin
      acc = longint'(dwell_ms) + longint'(t.tick_ms);
      dwell_ms = (acc > longint'(DWELL_MAX)) ? DWELL_MAX : acc[19:0];
      if (dwell_ms >= regs.dwell_duration_ms) begin
        at_dwell    = 1'b0;
        dwell_ms    = '0;
        run_len     = '0;
        wp_idx      = wp_idx + 8'd1;
        r.left_cell = 1'b1;
      end
    end else begin
      dx  = longint'($signed(t.pos_x)) - longint'($signed(t.target_x));
      dy  = longint'($signed(t.pos_y)) - longint'($signed(t.target_y));
      lim = longint'(regs.xy_tolerance);
      all_ok = (dx * dx + dy * dy <= lim * lim);
      dz = longint'($signed(t.pos_z)) - longint'($signed(regs.hold_altitude));
      if (dz < 0) dz = -dz;
      all_ok &= (dz <= longint'(regs.z_tolerance));
      dx  = longint'($signed(t.vel_x));
      dy  = longint'($signed(t.vel_y));
      lim = longint'(regs.xy_speed_limit);
      all_ok &= (dx * dx + dy * dy < lim * lim);
      dz = longint'($signed(t.vel_z));
      if (dz < 0) dz = -dz;
      all_ok &= (dz < longint'(regs.z_speed_limit));
      if (all_ok) begin
        if (run_len != STABLE_MAX) run_len = run_len + 8'd1;
      end else begin
        run_len = '0;
      end
      if (run_len >= regs.stable_ticks_needed) begin
        run_len        = '0;
        at_dwell       = 1'b1;
        dwell_ms       = '0;
        r.entered_cell = 1'b1;
      end
    end
    r.status           = 1'b0;
    r.waypoint_index   = wp_idx;
    r.in_dwell         = at_dwell;
    r.dwell_elapsed_ms = dwell_ms;
    r.stable_run       = run_len;
    r.setpoint_x       = t.target_x;
    r.setpoint_y       = t.target_y;
    return r;
  endfunction

  function automatic wads_item_t mk(input int px, py, pz, vx, vy, vz, tx, ty,
                                    input int ms, input bit early);
    wads_item_t t;
    t.pos_x = 16'(px);  t.pos_y = 16'(py);  t.pos_z = 16'(pz);
    t.vel_x = 16'(vx);  t.vel_y = 16'(vy);  t.vel_z = 16'(vz);
    t.target_x = 16'(tx);  t.target_y = 16'(ty);
    t.tick_ms = 10'(ms);
    t.finish_early = early;
    return t;
  endfunction

  function automatic wads_result_t done_at(input logic [7:0] idx);
    wads_result_t r;
    r = '0;
    r.status = 1'b1;
    r.waypoint_index = idx;
    return r;
  endfunction

  function automatic void add_tick(input wads_item_t t, input bit fixed, input wads_result_t want);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.reg_sel = REG_XY_TOL;
    row.value = '0;
    row.tick = t;
    row.fixed = fixed;
    row.want = want;
    script.push_back(row);
  endfunction

  function automatic void add_write(input wads_reg_t r, input int v);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.reg_sel = r;
    row.value = v;
    row.tick = '0;
    row.fixed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  // Random tick shaped by the current settings: mostly inside every
  // tolerance, some sitting right on a limit, the rest raw noise.
  function automatic wads_item_t make_tick(input int good_pct, input int ms_lo,
                                           input bit early_on);
    wads_item_t t;
    logic [159:0] raw;
    int roll, r, zr, vr, zl, s, e;
    roll = $urandom_range(0, 99);
    t.target_x = 16'($urandom);
    t.target_y = 16'($urandom);
    r  = regs.xy_tolerance / 2;
    t.pos_x = clip16(int'($signed(t.target_x)) + int'($urandom_range(0, 2 * r)) - r);
    t.pos_y = clip16(int'($signed(t.target_y)) + int'($urandom_range(0, 2 * r)) - r);
    zr = regs.z_tolerance;
    t.pos_z = clip16(int'($signed(regs.hold_altitude)) + int'($urandom_range(0, 2 * zr)) - zr);
    vr = (regs.xy_speed_limit == 0) ? 0 : (int'(regs.xy_speed_limit) - 1) / 2;
    t.vel_x = clip16(int'($urandom_range(0, 2 * vr)) - vr);
    t.vel_y = clip16(int'($urandom_range(0, 2 * vr)) - vr);
    zl = (regs.z_speed_limit == 0) ? 0 : int'(regs.z_speed_limit) - 1;
    t.vel_z = clip16(int'($urandom_range(0, 2 * zl)) - zl);
    if (roll >= good_pct && roll < (good_pct + 100) / 2) begin
      s = ($urandom_range(0, 1) == 0) ? -1 : 1;
      e = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: begin
          t.pos_x = clip16(int'($signed(t.target_x)) + s * (int'(regs.xy_tolerance) + e));
          t.pos_y = t.target_y;
        end
        1: t.pos_z = clip16(int'($signed(regs.hold_altitude)) + s * (int'(regs.z_tolerance) + e));
        2: begin
          t.vel_x = clip16(s * (int'(regs.xy_speed_limit) - 1 + e));
          t.vel_y = '0;
        end
        default: t.vel_z = clip16(s * (int'(regs.z_speed_limit) - 1 + e));
      endcase
    end else if (roll >= good_pct) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(wads_item_t)-1:0];
    end
    t.tick_ms = 10'($urandom_range(ms_lo, 1023));
    t.finish_early = early_on && ($urandom_range(0, 29) == 0);
    return t;
  endfunction

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_tick(input wads_item_t t, input bit fixed, input wads_result_t want);
    wads_result_t r;
    tick_bus <= t;
    push     <= 1'b1;
    do @(posedge clk); while (full);
    r = advance_sequencer(t);
    pending_results.push_back(fixed ? want : r);
  endtask

  // settle: no ticks in flight, every result back
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input wads_reg_t r, input logic [31:0] v);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(r, v);
  endtask

  task automatic set_config(input int xy_tol, z_tol, xy_spd, z_spd, need, dwell, count, hold);
    write_reg(REG_XY_TOL, xy_tol);
    write_reg(REG_Z_TOL, z_tol);
    write_reg(REG_XY_SPD, xy_spd);
    write_reg(REG_Z_SPD, z_spd);
    write_reg(REG_STABLE_REQ, need);
    write_reg(REG_DWELL_DUR, dwell);
    write_reg(REG_WP_COUNT, count);
    write_reg(REG_HOLD_ALT, hold);
  endtask

  task automatic run_phase(input int n, input int good_pct, input int ms_lo, input bit early_on);
    repeat (n) begin
      idle_burst();
      send_tick(make_tick(good_pct, ms_lo, early_on), 1'b0, '0);
    end
  endtask

  task automatic check_result(input wads_result_t got, input wads_result_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      n_bad++;
    end
    if (got.waypoint_index !== want.waypoint_index) begin
      $error("waypoint_index: expected %0d, got %0d", want.waypoint_index, got.waypoint_index);
      n_bad++;
    end
    if (got.in_dwell !== want.in_dwell) begin
      $error("in_dwell: expected %0d, got %0d", want.in_dwell, got.in_dwell);
      n_bad++;
    end
    if (got.entered_cell !== want.entered_cell) begin
      $error("entered_cell: expected %0d, got %0d", want.entered_cell, got.entered_cell);
      n_bad++;
    end
    if (got.left_cell !== want.left_cell) begin
      $error("left_cell: expected %0d, got %0d", want.left_cell, got.left_cell);
      n_bad++;
    end
    if (got.dwell_elapsed_ms !== want.dwell_elapsed_ms) begin
      $error("dwell_elapsed_ms: expected %0d, got %0d", want.dwell_elapsed_ms,
             got.dwell_elapsed_ms);
      n_bad++;
    end
    if (got.stable_run !== want.stable_run) begin
      $error("stable_run: expected %0d, got %0d", want.stable_run, got.stable_run);
      n_bad++;
    end
    if (got.setpoint_x !== want.setpoint_x) begin
      $error("setpoint_x: expected %0d, got %0d", want.setpoint_x, got.setpoint_x);
      n_bad++;
    end
    if (got.setpoint_y !== want.setpoint_y) begin
      $error("setpoint_y: expected %0d, got %0d", want.setpoint_y, got.setpoint_y);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      n_taken++;
      if (pending_results.size() == 0) begin
        $error("result taken with no tick outstanding");
        n_bad++;
      end else begin
        check_result(res_bus, pending_results.pop_front());
      end
    end
  end

  // result side: random stalls, one long hold-off so the input backs up
  initial begin : drain_side
    bit held_long;
    held_long = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && n_taken >= HOLD_AT) begin
        held_long = 1'b1;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rst      <= 1'b1;
    push     <= 1'b0;
    tick_bus <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    n_bad    = 0;
    n_taken  = 0;
    calm     = 1'b0;

    regs.xy_tolerance        = 16'd300;
    regs.z_tolerance         = 16'd200;
    regs.xy_speed_limit      = 16'd150;
    regs.z_speed_limit       = 16'd100;
    regs.stable_ticks_needed = 8'd10;
    regs.dwell_duration_ms   = 20'd2000;
    regs.waypoint_count      = 8'd0;
    regs.hold_altitude       = '0;
    at_dwell = 1'b0;
    run_len  = '0;
    dwell_ms = '0;
    wp_idx   = '0;

    // no waypoints after reset: every tick reports finished
    add_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, done_at(0));
    add_tick(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1023, 0),
             1'b1, done_at(0));
    add_tick(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 1),
             1'b1, done_at(0));
    add_write(REG_WP_COUNT, 2);
    add_write(REG_STABLE_REQ, 2);
    add_write(REG_DWELL_DUR, 5);
    // good, miss by one mm, good exactly on every limit, good -> arrival
    add_tick(mk(1000, -1000, 0, 0, 0, 0, 1000, -1000, 3, 0), 1'b0, '0);
    add_tick(mk(1301, -1000, 0, 0, 0, 0, 1000, -1000, 3, 0), 1'b0, '0);
    add_tick(mk(1300, -1000, 200, 149, 0, 99, 1000, -1000, 3, 0), 1'b0, '0);
    add_tick(mk(1000, -1000, -200, 0, -149, -99, 1000, -1000, 3, 0), 1'b0, '0);
    // dwell 3 + 2 ms meets 5 ms, index moves on
    add_tick(mk(0, 0, 0, 0, 0, 0, 1000, -1000, 3, 0), 1'b0, '0);
    add_tick(mk(0, 0, 0, 0, 0, 0, 1000, -1000, 2, 0), 1'b0, '0);
    add_tick(mk(0, 0, 0, 0, 0, 0, 500, 500, 7, 1), 1'b1, done_at(1));
    add_tick(mk(500, 500, 0, 0, 0, 100, 500, 500, 7, 0), 1'b0, '0);
    // no stable ticks required: arrival even on a miss
    add_write(REG_STABLE_REQ, 0);
    add_tick(mk(-20000, 20000, 9000, 5000, 5000, 5000, 500, 500, 7, 0), 1'b0, '0);
    // zero dwell leaves on the first dwell tick, then all waypoints done
    add_write(REG_DWELL_DUR, 0);
    add_tick(mk(0, 0, 0, 0, 0, 0, -7, 7, 0, 0), 1'b0, '0);
    add_tick(mk(0, 0, 0, 0, 0, 0, -7, 7, 9, 0), 1'b1, done_at(2));
    add_write(REG_WP_COUNT, 1);
    add_tick(mk(0, 0, 0, 0, 0, 0, -7, 7, 9, 0), 1'b1, done_at(2));
    // zero tolerances, widest speed limits
    add_write(REG_WP_COUNT, 255);
    add_write(REG_XY_TOL, 0);
    add_write(REG_Z_TOL, 0);
    add_write(REG_XY_SPD, 65535);
    add_write(REG_Z_SPD, 65535);
    add_write(REG_STABLE_REQ, 1);
    add_tick(mk(-32768, 32767, 0, -32768, -32768, -32768, -32768, 32767, 0, 0), 1'b0, '0);
    add_write(REG_DWELL_DUR, 1);
    add_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 1023, 0), 1'b0, '0);
    // widest tolerances, zero speed limits never pass, then limit of one
    add_write(REG_HOLD_ALT, -32768);
    add_write(REG_Z_TOL, 65535);
    add_write(REG_XY_TOL, 65535);
    add_write(REG_XY_SPD, 0);
    add_write(REG_Z_SPD, 0);
    add_tick(mk(32767, 0, 32767, 0, 0, 0, -32768, 0, 5, 0), 1'b0, '0);
    add_write(REG_XY_SPD, 1);
    add_write(REG_Z_SPD, 1);
    add_tick(mk(32767, 0, 32767, 0, 0, 0, -32768, 0, 5, 0), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        idle_burst();
        send_tick(script[i].tick, script[i].fixed, script[i].want);
      end
    end

    // ordinary traversal; the long receiver stall falls in here
    set_config(300, 200, 150, 100, 3, $urandom_range(0, 3000), cap_count(wp_idx + 4),
               int'($urandom_range(0, 2000)) - 1000);
    run_phase(80, 85, 0, 1'b1);

    // longest dwell: the accumulator runs into its ceiling before leaving
    set_config(300, 200, 150, 100, 1, int'(DWELL_MAX), cap_count(wp_idx + 1), 0);
    run_phase(1060, 100, 1000, 1'b0);

    repeat (6) begin
      set_config(pick(0, 65535, 50, 3000), pick(0, 65535, 20, 1500),
                 pick(0, 65535, 20, 1500), pick(0, 65535, 20, 1500),
                 pick(0, 255, 0, 6), pick(0, int'(DWELL_MAX), 0, 3000),
                 ($urandom_range(0, 5) == 0) ? 0 : cap_count(wp_idx + $urandom_range(0, 3)),
                 pick(-32768, 32767, -3000, 3000));
      run_phase(20, 60, 0, 1'b1);
    end

    // quick waypoint turnover, no idling on either side
    set_config(300, 200, 150, 100, 0, 0, MAX_WP, 0);
    calm = 1'b1;
    run_phase(80, 70, 0, 1'b1);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
